/* rtl/core/sdu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared types and codes for the signed division unit.
// ----------------------------------------------------------------------------
package sdu_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] REG_DIVISOR   = 3'd0;
  localparam logic [2:0] REG_DVD32     = 3'd1;
  localparam logic [2:0] REG_DVD_HIGH  = 3'd2;
  localparam logic [2:0] REG_DVD_LOW   = 3'd3;
  localparam logic [2:0] REG_CONTROL   = 3'd4;

  localparam logic [0:0] CFG_VECTOR   = 1'd0;
  localparam logic [0:0] CFG_PRIORITY = 1'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  tick_count;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        busy_res;
    logic        irq_request;
    logic [7:0]  irq_vector;
    logic [3:0]  irq_level;
  } result_t;

  typedef struct packed {
    logic [63:0] num_mag;
    logic [31:0] den_mag;
    logic        num_neg;
    logic        den_neg;
  } div_req_t;

  typedef struct packed {
    logic [31:0] quot;
    logic [31:0] rem;
    logic        ovf;
  } div_res_t;

endpackage

/* rtl/core/sdu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface sdu_if #(parameter type payload_t = logic [0:0]) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/sdu_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sdu_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sdu_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdu_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sdu_pkg::div_req_t   req,
  output logic                done,
  output sdu_pkg::div_res_t   res
);
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic        nneg_r, dneg_r, zero_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r;
  logic [33:0] trial;
  logic [63:0] q_s;
  logic [63:0] r_s;

  assign trial = {rem_r, quo_r[63]} - {2'b0, den_r};

  always_comb begin
    rem_nxt = {rem_r[31:0], quo_r[63]};
    quo_nxt = {quo_r[62:0], 1'b0};
    if (!trial[33]) begin
      rem_nxt = trial[32:0];
      quo_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_nxt == 7'd0) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= req.num_mag;
      rem_r  <= '0;
      den_r  <= req.den_mag;
      nneg_r <= req.num_neg;
      dneg_r <= req.den_neg;
      zero_r <= (req.den_mag == 32'd0);
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = busy_r && (cnt_r == 7'd1);

  always_comb begin
    q_s = (nneg_r != dneg_r) ? (64'd0 - quo_nxt) : quo_nxt;
    r_s = nneg_r ? (64'd0 - {31'd0, rem_nxt}) : {31'd0, rem_nxt};
    if (zero_r) begin
      q_s = '0;
      r_s = '0;
    end
    res.quot = q_s[31:0];
    res.rem  = r_s[31:0];
    res.ovf  = zero_r ||
      (nneg_r && dneg_r && q_s == 64'h7FFF_FFFF && r_s[31]);
  end
endmodule

/* rtl/core/sdu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_front
// Accepts items, queues them two deep for the back end.
// ----------------------------------------------------------------------------
module sdu_front (
  input  logic          clk,
  input  logic          rst_n,
  sdu_if.sink           in_ch,
  output logic          q_valid,
  output sdu_pkg::item_t q_item,
  input  logic          q_pop
);
  sdu_pkg::item_t buf_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_ch.data;
  end
endmodule

/* rtl/core/sdu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_back
// Register file, countdown and division control; emits one result per word.
// ----------------------------------------------------------------------------
module sdu_back #(
  parameter int NORMAL_LATENCY   = 39,
  parameter int OVERFLOW_LATENCY = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  sdu_pkg::item_t q_item,
  output logic           q_pop,
  sdu_cfg_if.sink        cfg_ch,
  sdu_if.source          out_ch
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [31:0] dvs_r, dh_r, dl_r, pq_r, pr_r;
  logic [31:0] dvs_nxt, dh_nxt, dl_nxt, pq_nxt, pr_nxt;
  logic [1:0]  ctl_r, ctl_nxt;
  logic [5:0]  left_r, left_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  vec_r;
  logic [3:0]  pri_r;
  sdu_pkg::result_t res_r, res_nxt;
  logic        start;
  logic        done;
  sdu_pkg::div_req_t req;
  sdu_pkg::div_res_t dres;
  logic [31:0] hi_w;
  logic [63:0] num;
  logic [31:0] rd;
  logic        div_start;

  sdu_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .req(req),
                     .done(done), .res(dres));

  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (st_r == ST_OUT);
  assign out_ch.data  = res_r;
  assign q_pop = (st_r == ST_IDLE) && q_valid;
  assign start = q_pop && q_item.command == sdu_pkg::CMD_WRITE &&
                 (q_item.reg_index == sdu_pkg::REG_DVD32 ||
                  q_item.reg_index == sdu_pkg::REG_DVD_LOW);

  always_comb begin
    hi_w = (q_item.reg_index == sdu_pkg::REG_DVD32) ?
           {32{q_item.write_data[31]}} : dh_r;
    num = {hi_w, q_item.write_data};
    req.num_neg = hi_w[31];
    req.den_neg = dvs_r[31];
    req.num_mag = hi_w[31] ? (64'd0 - num) : num;
    req.den_mag = dvs_r[31] ? (32'd0 - dvs_r) : dvs_r;
  end
  assign div_start = start;

  always_comb begin
    case (q_item.reg_index)
      sdu_pkg::REG_DIVISOR:  rd = dvs_r;
      sdu_pkg::REG_DVD32:    rd = dl_r;
      sdu_pkg::REG_DVD_HIGH: rd = dh_r;
      sdu_pkg::REG_DVD_LOW:  rd = dl_r;
      sdu_pkg::REG_CONTROL:  rd = {30'd0, ctl_r};
      default:               rd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r <= '0;
      pri_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == sdu_pkg::CFG_VECTOR) vec_r <= cfg_ch.data[7:0];
      else pri_r <= cfg_ch.data[3:0];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    dvs_nxt  = dvs_r;
    dh_nxt   = dh_r;
    dl_nxt   = dl_r;
    pq_nxt   = pq_r;
    pr_nxt   = pr_r;
    ctl_nxt  = ctl_r;
    left_nxt = left_r;
    run_nxt  = run_r;
    res_nxt  = res_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          res_nxt = '0;
          res_nxt.busy_res = run_r;
          st_nxt = ST_OUT;
          case (q_item.command)
            sdu_pkg::CMD_READ: res_nxt.read_data = rd;
            sdu_pkg::CMD_WRITE: begin
              case (q_item.reg_index)
                sdu_pkg::REG_DIVISOR:  dvs_nxt = q_item.write_data;
                sdu_pkg::REG_DVD32: begin
                  dl_nxt = q_item.write_data;
                  dh_nxt = hi_w;
                  st_nxt = ST_DIV;
                end
                sdu_pkg::REG_DVD_HIGH: dh_nxt = q_item.write_data;
                sdu_pkg::REG_DVD_LOW: begin
                  dl_nxt = q_item.write_data;
                  st_nxt = ST_DIV;
                end
                sdu_pkg::REG_CONTROL:  ctl_nxt = q_item.write_data[1:0];
                default: ;
              endcase
            end
            sdu_pkg::CMD_TICK: begin
              if (run_r && q_item.tick_count != 8'd0) begin
                if ({2'b0, left_r} <= q_item.tick_count) begin
                  if (ctl_r[0]) begin
                    if (ctl_r[1]) begin
                      res_nxt.irq_request = 1'b1;
                      res_nxt.irq_vector  = vec_r;
                      res_nxt.irq_level   = pri_r;
                    end
                  end else begin
                    dl_nxt = pq_r;
                    dh_nxt = pr_r;
                  end
                  left_nxt = '0;
                  run_nxt = 1'b0;
                  res_nxt.busy_res = 1'b0;
                end else begin
                  left_nxt = left_r - q_item.tick_count[5:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (done) begin
          pq_nxt = dres.quot;
          pr_nxt = dres.rem;
          ctl_nxt[0] = ctl_r[0] | dres.ovf;
          left_nxt = (ctl_r[0] | dres.ovf) ? 6'(OVERFLOW_LATENCY) : 6'(NORMAL_LATENCY);
          run_nxt = 1'b1;
          res_nxt.busy_res = 1'b1;
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: if (out_ch.ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      dvs_r <= '0; dh_r <= '0; dl_r <= '0; pq_r <= '0; pr_r <= '0;
      ctl_r <= '0; left_r <= '0; run_r <= 1'b0;
      res_r <= '0;
    end else begin
      st_r   <= st_nxt;
      dvs_r  <= dvs_nxt;
      dh_r   <= dh_nxt;
      dl_r   <= dl_nxt;
      pq_r   <= pq_nxt;
      pr_r   <= pr_nxt;
      ctl_r  <= ctl_nxt;
      left_r <= left_nxt;
      run_r  <= run_nxt;
      res_r  <= res_nxt;
    end
  end
endmodule

/* rtl/core/signed_division_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_division_unit
// Register-mapped signed 64/32 divider with countdown and overflow interrupt.
// ----------------------------------------------------------------------------
// The in_ channel carries bus words: register reads, writes and time ticks.
// Each word yields one result word on the out_ channel. The cfg_ channel
// sets the overflow interrupt vector and level and is always ready.
// A two-word queue separates intake from execution. The back end takes one
// word at a time. A read, a plain write or a tick can deliver its result at
// the next clock edge and holds the back end until that result is taken. A
// write that starts a division runs the bit-serial divider; its result is
// registered when the divider signals done, and the word holds the back end
// until that result is taken. Reset clears all registers and the queue.
// While the receiver stalls, the result is held and intake continues until
// the queue is full.
// ----------------------------------------------------------------------------
module signed_division_unit #(
  parameter int NORMAL_LATENCY   = 39,
  parameter int OVERFLOW_LATENCY = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sdu_pkg::item_t        in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sdu_pkg::result_t      out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  sdu_if #(.payload_t(sdu_pkg::item_t))   in_ch (clk);
  sdu_if #(.payload_t(sdu_pkg::result_t)) out_ch (clk);
  sdu_cfg_if cfg_ch (clk);
  logic           q_valid;
  logic           q_pop;
  sdu_pkg::item_t q_item;

  assign in_ch.valid = in_valid;
  assign in_ch.data  = in_data;
  assign in_ready    = in_ch.ready;
  assign out_valid   = out_ch.valid;
  assign out_data    = out_ch.data;
  assign out_ch.ready = out_ready;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.index = cfg_index;
  assign cfg_ch.data  = cfg_data;
  assign cfg_ready    = cfg_ch.ready;

  sdu_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
                     .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

  sdu_back #(.NORMAL_LATENCY(NORMAL_LATENCY), .OVERFLOW_LATENCY(OVERFLOW_LATENCY))
    u_back (.clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
            .q_pop(q_pop), .cfg_ch(cfg_ch.sink), .out_ch(out_ch.source));
endmodule

/* test/sdu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdu_checker
// Watches the bus, result and configuration channels of the division unit.
// ----------------------------------------------------------------------------
// Every accepted bus word is run through a local copy of the register file,
// the divider and the countdown. The predicted result word is queued and
// compared field by field with each result word the unit delivers.
// Configuration writes are tracked so that interrupt vector and level are
// predicted too.
// ----------------------------------------------------------------------------
module sdu_checker #(
  parameter int NORMAL_LATENCY   = 39,
  parameter int OVERFLOW_LATENCY = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  sdu_pkg::item_t   in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  sdu_pkg::result_t out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output int               fail_count,
  output int               words_pending,
  output int               words_checked
);

  logic [7:0]  ovf_vector;
  logic [3:0]  ovf_level;
  logic [31:0] divisor;
  logic [31:0] dvd_high;
  logic [31:0] dvd_low;
  logic [1:0]  ctrl;
  logic [31:0] quot_hold;
  logic [31:0] rem_hold;
  logic [5:0]  cycles_left;
  logic        running;

  sdu_pkg::result_t expected_words[$];

  initial begin
    fail_count    = 0;
    words_checked = 0;
    words_pending = 0;
  end

  task automatic report(input string field, input logic [31:0] exp_v,
                        input logic [31:0] got_v);
    $display("%0t: mismatch in %s: expected %h, got %h", $realtime, field, exp_v, got_v);
    fail_count++;
  endtask

  function automatic void start_division();
    logic [63:0] num;
    logic [63:0] nmag;
    logic [63:0] dmag;
    logic [63:0] q;
    logic [63:0] r;
    logic        nneg;
    logic        dneg;
    num  = {dvd_high, dvd_low};
    nneg = dvd_high[31];
    dneg = divisor[31];
    q    = '0;
    r    = '0;
    if (divisor == 32'd0) begin
      ctrl[0] = 1'b1;
    end else begin
      nmag = nneg ? -num : num;
      dmag = {32'd0, dneg ? -divisor : divisor};
      q = nmag / dmag;
      r = nmag % dmag;
      if (nneg != dneg) q = -q;
      if (nneg) r = -r;
    end
    if (nneg && dneg && q == 64'h7FFF_FFFF && r[31]) ctrl[0] = 1'b1;
    cycles_left = ctrl[0] ? 6'(OVERFLOW_LATENCY) : 6'(NORMAL_LATENCY);
    quot_hold = q[31:0];
    rem_hold  = r[31:0];
    running   = 1'b1;
  endfunction

  function automatic sdu_pkg::result_t apply_word(input sdu_pkg::item_t w);
    sdu_pkg::result_t res;
    res = '0;
    case (w.command)
      sdu_pkg::CMD_READ: begin
        case (w.reg_index)
          sdu_pkg::REG_DIVISOR:  res.read_data = divisor;
          sdu_pkg::REG_DVD32:    res.read_data = dvd_low;
          sdu_pkg::REG_DVD_HIGH: res.read_data = dvd_high;
          sdu_pkg::REG_DVD_LOW:  res.read_data = dvd_low;
          sdu_pkg::REG_CONTROL:  res.read_data = {30'd0, ctrl};
          default:               res.read_data = '0;
        endcase
      end
      sdu_pkg::CMD_WRITE: begin
        case (w.reg_index)
          sdu_pkg::REG_DIVISOR: divisor = w.write_data;
          sdu_pkg::REG_DVD32: begin
            dvd_low  = w.write_data;
            dvd_high = {32{w.write_data[31]}};
            start_division();
          end
          sdu_pkg::REG_DVD_HIGH: dvd_high = w.write_data;
          sdu_pkg::REG_DVD_LOW: begin
            dvd_low = w.write_data;
            start_division();
          end
          sdu_pkg::REG_CONTROL: ctrl = w.write_data[1:0];
          default: ;
        endcase
      end
      sdu_pkg::CMD_TICK: begin
        if (running && w.tick_count != 8'd0) begin
          if ({24'd0, w.tick_count} >= {26'd0, cycles_left}) begin
            if (ctrl[0]) begin
              if (ctrl[1]) res.irq_request = 1'b1;
            end else begin
              dvd_low  = quot_hold;
              dvd_high = rem_hold;
            end
            cycles_left = '0;
            running     = 1'b0;
          end else begin
            cycles_left = cycles_left - w.tick_count[5:0];
          end
        end
      end
      default: ;
    endcase
    res.busy_res = running;
    if (res.irq_request) begin
      res.irq_vector = ovf_vector;
      res.irq_level  = ovf_level;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    sdu_pkg::result_t exp_w;
    if (!rst_n) begin
      ovf_vector  <= '0;
      ovf_level   <= '0;
      divisor     = '0;
      dvd_high    = '0;
      dvd_low     = '0;
      ctrl        = '0;
      quot_hold   = '0;
      rem_hold    = '0;
      cycles_left = '0;
      running     = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sdu_pkg::CFG_VECTOR) ovf_vector <= cfg_data[7:0];
        else ovf_level <= cfg_data[3:0];
      end
      if (in_valid && in_ready) expected_words.push_back(apply_word(in_data));
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          report("unexpected word", 32'd0, out_data.read_data);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data.read_data !== exp_w.read_data)
            report("read_data", exp_w.read_data, out_data.read_data);
          if (out_data.busy_res !== exp_w.busy_res)
            report("busy_res", 32'(exp_w.busy_res), 32'(out_data.busy_res));
          if (out_data.irq_request !== exp_w.irq_request)
            report("irq_request", 32'(exp_w.irq_request), 32'(out_data.irq_request));
          if (out_data.irq_vector !== exp_w.irq_vector)
            report("irq_vector", 32'(exp_w.irq_vector), 32'(out_data.irq_vector));
          if (out_data.irq_level !== exp_w.irq_level)
            report("irq_level", 32'(exp_w.irq_level), 32'(out_data.irq_level));
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

/* test/signed_division_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_division_unit_tb
// Stimulus and verdict for the signed division unit.
// ----------------------------------------------------------------------------
// A directed part covers zero divisors, the negative overflow check, the
// sticky flag with the interrupt enabled, restarts, wrapping quotients and
// unknown commands and registers. Random division sequences and noise words
// follow in four phases, each with its own interrupt vector and level.
// Both sides idle at random, except in one phase that runs without gaps.
// ----------------------------------------------------------------------------
module signed_division_unit_tb;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int WORDS_PER_PHASE = 425;

  logic clk;
  logic rst_n;
  logic steady;
  int   cycle_count;
  int   words_sent;
  int   fail_count;
  int   words_pending;
  int   words_checked;

  sdu_if #(.payload_t(sdu_pkg::item_t))   in_ch (clk);
  sdu_if #(.payload_t(sdu_pkg::result_t)) out_ch (clk);
  sdu_cfg_if                              cfg_ch (clk);

  signed_division_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data)
  );

  sdu_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= steady || ($urandom_range(99) >= 30);
  end

  function automatic sdu_pkg::item_t mk(input logic [1:0] cmd, input logic [2:0] idx,
                                        input logic [31:0] wdata,
                                        input logic [7:0] ticks);
    sdu_pkg::item_t w;
    w.command    = cmd;
    w.reg_index  = idx;
    w.write_data = wdata;
    w.tick_count = ticks;
    return w;
  endfunction

  task automatic send(input sdu_pkg::item_t w);
    while (!steady && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= sdu_pkg::item_t'($bits(sdu_pkg::item_t)'({$urandom, $urandom}));
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic wr(input logic [2:0] idx, input logic [31:0] wdata);
    send(mk(sdu_pkg::CMD_WRITE, idx, wdata, 8'($urandom)));
  endtask

  task automatic rd(input logic [2:0] idx);
    send(mk(sdu_pkg::CMD_READ, idx, $urandom, 8'($urandom)));
  endtask

  task automatic tick(input logic [7:0] ticks);
    send(mk(sdu_pkg::CMD_TICK, 3'($urandom), $urandom, ticks));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] wdata);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= wdata;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_divisor();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'(1 + $urandom_range(15));
      3:       return -32'(1 + $urandom_range(15));
      4:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic division_sequence();
    int spent;
    logic [7:0] ticks;
    if ($urandom_range(3) == 0) wr(sdu_pkg::REG_CONTROL, $urandom);
    wr(sdu_pkg::REG_DIVISOR, pick_divisor());
    if ($urandom_range(1)) begin
      wr(sdu_pkg::REG_DVD32, $urandom);
    end else begin
      case ($urandom_range(3))
        0:       wr(sdu_pkg::REG_DVD_HIGH, 32'd0);
        1:       wr(sdu_pkg::REG_DVD_HIGH, 32'hFFFF_FFFF);
        default: wr(sdu_pkg::REG_DVD_HIGH, $urandom);
      endcase
      wr(sdu_pkg::REG_DVD_LOW, $urandom);
    end
    spent = 0;
    while (spent < 40 && $urandom_range(9) != 0) begin
      ticks = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      tick(ticks);
      spent += ticks;
    end
    rd(sdu_pkg::REG_DVD_LOW);
    rd(sdu_pkg::REG_DVD_HIGH);
    if ($urandom_range(1)) rd(sdu_pkg::REG_CONTROL);
  endtask

  task automatic noise_word();
    send(mk(2'($urandom), 3'($urandom), $urandom, 8'($urandom)));
  endtask

  initial begin
    int phase;
    int phase_end;
    rst_n        <= 1'b0;
    steady       <= 1'b0;
    cycle_count  <= 0;
    words_sent   = 0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= sdu_pkg::CFG_VECTOR;
    cfg_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(sdu_pkg::CFG_VECTOR, 32'hA5);
    cfg_write(sdu_pkg::CFG_PRIORITY, 32'h9);

    // Idle reads, idle tick, unknown register and unknown command.
    rd(sdu_pkg::REG_CONTROL);
    tick(8'd0);
    tick(8'd255);
    wr(3'd7, 32'hFFFF_FFFF);
    rd(3'd5);
    send(mk(2'd3, 3'd6, 32'hFFFF_FFFF, 8'hFF));
    // Zero divisor with the interrupt enabled: sticky flag, short countdown.
    wr(sdu_pkg::REG_CONTROL, 32'h2);
    wr(sdu_pkg::REG_DIVISOR, 32'd0);
    wr(sdu_pkg::REG_DVD32, 32'h7FFF_FFFF);
    rd(sdu_pkg::REG_CONTROL);
    tick(8'd5);
    tick(8'd1);
    // Negative by negative with a quotient of 0x7FFFFFFF and negative remainder.
    wr(sdu_pkg::REG_CONTROL, 32'h2);
    wr(sdu_pkg::REG_DIVISOR, 32'hFFFF_FFFE);
    wr(sdu_pkg::REG_DVD_HIGH, 32'hFFFF_FFFF);
    wr(sdu_pkg::REG_DVD_LOW, 32'h0000_0001);
    tick(8'd255);
    // Most negative dividend by minus one, restarted while running.
    wr(sdu_pkg::REG_CONTROL, 32'h0);
    wr(sdu_pkg::REG_DIVISOR, 32'hFFFF_FFFF);
    wr(sdu_pkg::REG_DVD32, 32'h8000_0000);
    tick(8'd38);
    wr(sdu_pkg::REG_DVD32, 32'h8000_0000);
    tick(8'd39);
    rd(sdu_pkg::REG_DVD32);
    rd(sdu_pkg::REG_DVD_HIGH);
    rd(sdu_pkg::REG_DIVISOR);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          cfg_write(sdu_pkg::CFG_VECTOR, 32'h0);
          cfg_write(sdu_pkg::CFG_PRIORITY, 32'h0);
        end
        1: begin
          cfg_write(sdu_pkg::CFG_VECTOR, 32'hFF);
          cfg_write(sdu_pkg::CFG_PRIORITY, 32'hF);
        end
        default: begin
          cfg_write(sdu_pkg::CFG_VECTOR, $urandom);
          cfg_write(sdu_pkg::CFG_PRIORITY, $urandom);
        end
      endcase
      steady <= (phase == 2);
      phase_end = words_sent + WORDS_PER_PHASE;
      while (words_sent < phase_end) begin
        if ($urandom_range(4) == 0) noise_word();
        else division_sequence();
      end
      drain();
    end
    steady <= 1'b0;

    $display("Sent %0d bus words, checked %0d result words over four", words_sent,
             words_checked);
    $display("interrupt settings with random gaps on both sides.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* signed_division_unit.f */
rtl/core/sdu_pkg.sv
rtl/core/sdu_if.sv
rtl/core/sdu_cfg_if.sv
rtl/core/sdu_divider.sv
rtl/core/sdu_front.sv
rtl/core/sdu_back.sv
rtl/core/signed_division_unit.sv
test/sdu_checker.sv
test/signed_division_unit_tb.sv
